// ===== hw/rtl/srtv_pkg.sv =====
// Package for the scale/rotate/translate vector block.
// Holds the op codes, register indexes and the control structs shared by the
// top level and the divider stage. No dependencies.
package srtv_pkg;

  localparam logic [1:0] OP_FWD          = 2'd0;
  localparam logic [1:0] OP_FWD_NOSCALE  = 2'd1;
  localparam logic [1:0] OP_INV          = 2'd2;
  localparam logic [1:0] OP_INV_NOSCALE  = 2'd3;

  localparam logic [2:0] REG_ROTATION = 3'd0;
  localparam logic [2:0] REG_TRANS_X  = 3'd1;
  localparam logic [2:0] REG_TRANS_Y  = 3'd2;
  localparam logic [2:0] REG_TRANS_Z  = 3'd3;
  localparam logic [2:0] REG_SCALE_X  = 3'd4;
  localparam logic [2:0] REG_SCALE_Y  = 3'd5;
  localparam logic [2:0] REG_SCALE_Z  = 3'd6;

  localparam int QUAT_FRAC = 14;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    logic pos;
    logic inverse;
    logic scaled;
    logic err;
  } ctl_t;

  // Per-axis sign information for the divide path.
  typedef struct packed {
    logic neg;
    logic bzero;
    logic aneg;
  } axis_t;

endpackage

// ===== hw/rtl/srtv_div_stage.sv =====
// One stage of the pipelined restoring divider used by the inverse scale.
// Retires up to STEPS quotient bits per axis per cycle unless the next stage stalls it. Depends on srtv_pkg.
module srtv_div_stage
  import srtv_pkg::*;
#(
  parameter int DW    = 32,
  parameter int FRAC  = 16,
  parameter int STAGE = 0,
  parameter int STEPS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ctl_t                      in_ctl,
  input  axis_t [2:0]               in_axis,
  input  logic [2:0][DW-1:0]        in_fwd,
  input  logic [2:0][DW-1:0]        in_ub,
  input  logic [2:0][DW:0]          in_rem,
  input  logic [2:0][DW+FRAC-1:0]   in_dq,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ctl_t                      out_ctl,
  output axis_t [2:0]               out_axis,
  output logic [2:0][DW-1:0]        out_fwd,
  output logic [2:0][DW-1:0]        out_ub,
  output logic [2:0][DW:0]          out_rem,
  output logic [2:0][DW+FRAC-1:0]   out_dq
);

  localparam int TOT  = DW + FRAC;
  localparam int BASE = STAGE * STEPS;

  logic                    vld_r;
  ctl_t                    ctl_r;
  axis_t [2:0]             axis_r;
  logic [2:0][DW-1:0]      fwd_r;
  logic [2:0][DW-1:0]      ub_r;
  logic [2:0][DW:0]        rem_r, rem_nxt;
  logic [2:0][TOT-1:0]     dq_r, dq_nxt;

  assign in_ready = !vld_r || out_ready;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    logic [DW:0]    r;
    logic [TOT-1:0] d;
    for (int a = 0; a < 3; a++) begin
      r = in_rem[a];
      d = in_dq[a];
      for (int j = 0; j < STEPS; j++) begin
        if (BASE + j < TOT) begin
          r = {r[DW-1:0], d[TOT-1]};
          d = {d[TOT-2:0], 1'b0};
          if (r >= {1'b0, in_ub[a]}) begin
            r = r - {1'b0, in_ub[a]};
            d[0] = 1'b1;
          end
        end
      end
      rem_nxt[a] = r;
      dq_nxt[a]  = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ctl_r  <= in_ctl;
      axis_r <= in_axis;
      fwd_r  <= in_fwd;
      ub_r   <= in_ub;
      rem_r  <= rem_nxt;
      dq_r   <= dq_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_ctl   = ctl_r;
  assign out_axis  = axis_r;
  assign out_fwd   = fwd_r;
  assign out_ub    = ub_r;
  assign out_rem   = rem_r;
  assign out_dq    = dq_r;

endmodule

// ===== hw/rtl/scale_rotate_translate_vector.sv =====
// Top level of the scale/rotate/translate vector block: register file,
// scale, quaternion rotation and translation stages. Depends on srtv_pkg
// and srtv_div_stage.
//
// One 3-D vector enters per cycle unless a stall backs up to the input. Six
// stages cover scale or translation removal, the two rotation product levels
// and the final translation; the inverse scale divide runs through a
// restoring divider pipeline that retires four quotient bits per axis per
// stage, followed by an output register. Each stage holds its item on a
// stall and bubbles close up, so new items are taken while a finished
// result waits. All items run the full pipeline.
module scale_rotate_translate_vector
  import srtv_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [5:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic                         in_is_position,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  input  logic signed [DATA_WIDTH-1:0] in_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_y,
  output logic signed [DATA_WIDTH-1:0] out_z,
  output logic                         out_is_position,
  output logic                         out_range_error
);

  localparam int DW    = DATA_WIDTH;
  localparam int SW    = 2 * DW + 2;
  localparam int TW    = DW + 5;
  localparam int UW    = DW + 10;
  localparam int TOT   = DW + FRAC_BITS;
  localparam int STEPS = 4;
  localparam int NSTG  = (TOT + STEPS - 1) / STEPS;

  localparam logic signed [SW-1:0] MAX_W = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_W = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // Clamp to the data range; the top bit of the result flags a clamp.
  function automatic logic [DW:0] sat_f(input logic signed [SW-1:0] x);
    if (x > MAX_W) begin
      return {1'b1, MAX_W[DW-1:0]};
    end else if (x < MIN_W) begin
      return {1'b1, MIN_W[DW-1:0]};
    end
    return {1'b0, x[DW-1:0]};
  endfunction

  // Configuration registers
  logic [63:0]          rot_r;
  logic signed [DW-1:0] tr_r [3];
  logic signed [DW-1:0] sc_r [3];
  logic                 wr_en;
  logic [2:0]           widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= 64'(1) << (48 + QUAT_FRAC);
      for (int k = 0; k < 3; k++) begin
        tr_r[k] <= '0;
        sc_r[k] <= DW'(1) << FRAC_BITS;
      end
    end else if (wr_en) begin
      unique case (widx)
        REG_ROTATION: rot_r    <= pwdata;
        REG_TRANS_X:  tr_r[0]  <= pwdata[DW-1:0];
        REG_TRANS_Y:  tr_r[1]  <= pwdata[DW-1:0];
        REG_TRANS_Z:  tr_r[2]  <= pwdata[DW-1:0];
        REG_SCALE_X:  sc_r[0]  <= pwdata[DW-1:0];
        REG_SCALE_Y:  sc_r[1]  <= pwdata[DW-1:0];
        REG_SCALE_Z:  sc_r[2]  <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_ROTATION: prdata = rot_r;
      REG_TRANS_X:  prdata = 64'(unsigned'(tr_r[0]));
      REG_TRANS_Y:  prdata = 64'(unsigned'(tr_r[1]));
      REG_TRANS_Z:  prdata = 64'(unsigned'(tr_r[2]));
      REG_SCALE_X:  prdata = 64'(unsigned'(sc_r[0]));
      REG_SCALE_Y:  prdata = 64'(unsigned'(sc_r[1]));
      REG_SCALE_Z:  prdata = 64'(unsigned'(sc_r[2]));
      default:      prdata = '0;
    endcase
  end

  // Op decode
  ctl_t in_ctl;
  always_comb begin
    in_ctl     = '0;
    in_ctl.pos = in_is_position;
    unique case (in_op)
      OP_FWD:         begin in_ctl.inverse = 1'b0; in_ctl.scaled = 1'b1; end
      OP_FWD_NOSCALE: begin in_ctl.inverse = 1'b0; in_ctl.scaled = 1'b0; end
      OP_INV:         begin in_ctl.inverse = 1'b1; in_ctl.scaled = 1'b1; end
      OP_INV_NOSCALE: begin in_ctl.inverse = 1'b1; in_ctl.scaled = 1'b0; end
      default:        begin in_ctl.inverse = 1'b0; in_ctl.scaled = 1'b0; end
    endcase
  end

  // Stage control
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r;
  logic en1, en2, en3, en4, en5, en6;
  ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r;
  logic div_in_ready;
  logic en_out;

  assign en6 = !vld6_r || div_in_ready;
  assign en5 = !vld5_r || en6;
  assign en4 = !vld4_r || en5;
  assign en3 = !vld3_r || en4;
  assign en2 = !vld2_r || en3;
  assign en1 = !vld1_r || en2;
  assign in_ready = en1;

  logic signed [DW-1:0] vin [3];
  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  // Rotation quaternion, conjugated per item where the op is inverse.
  logic signed [16:0] qraw [3];
  logic signed [16:0] qw;
  logic signed [16:0] q3 [3];
  logic signed [16:0] q4 [3];

  assign qw = {rot_r[63], rot_r[63:48]};

  logic signed [SW-1:0] pre1_r [3];
  logic signed [DW-1:0] v2_r [3];
  logic signed [DW-1:0] v3_r [3];
  logic signed [TW-1:0] t3_r [3];
  logic signed [DW-1:0] v4_r [3];
  logic signed [UW-1:0] u4_r [3];
  logic signed [DW-1:0] o5_r [3];
  logic [2:0]           e2, e5, e6;
  logic [2:0][DW-1:0]   fwd6_r;
  logic [2:0][DW-1:0]   ub6_r;
  logic [2:0][TOT-1:0]  dq6_r;
  axis_t [2:0]          axis6_r;

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_axis
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;

      logic signed [2*DW-1:0] prod;
      logic signed [SW-1:0]   pre_nxt;
      logic [DW:0]            s2;
      logic signed [DW+16:0]  pa, pb;
      logic signed [DW+17:0]  tsum;
      logic signed [TW+16:0]  ma, mb, mc;
      logic signed [TW+18:0]  usum;
      logic [DW:0]            s5;
      logic [DW:0]            s6;
      logic                   oneg;

      assign qraw[k] = {rot_r[16*k+15], rot_r[16*k+15 -: 16]};
      assign q3[k]   = ctl2_r.inverse ? -qraw[k] : qraw[k];
      assign q4[k]   = ctl3_r.inverse ? -qraw[k] : qraw[k];

      assign prod = vin[k] * sc_r[k];
      always_comb begin
        if (!in_ctl.inverse) begin
          pre_nxt = in_ctl.scaled ? SW'(prod) : (SW'(vin[k]) <<< FRAC_BITS);
        end else if (in_is_position) begin
          pre_nxt = SW'(vin[k]) - SW'(tr_r[k]);
        end else begin
          pre_nxt = SW'(vin[k]);
        end
      end

      assign s2    = sat_f(ctl1_r.inverse ? pre1_r[k] : (pre1_r[k] >>> FRAC_BITS));
      assign e2[k] = s2[DW];

      assign pa   = q3[K1] * v2_r[K2];
      assign pb   = q3[K2] * v2_r[K1];
      assign tsum = (DW+18)'(pa) - (DW+18)'(pb);

      assign ma   = qw * t3_r[k];
      assign mb   = q4[K1] * t3_r[K2];
      assign mc   = q4[K2] * t3_r[K1];
      assign usum = (TW+19)'(ma) + (TW+19)'(mb) - (TW+19)'(mc);

      assign s5    = sat_f(SW'(v4_r[k]) + SW'(u4_r[k]));
      assign e5[k] = s5[DW];

      assign s6    = sat_f(SW'(o5_r[k]) + SW'(tr_r[k]));
      assign e6[k] = ctl5_r.pos && !ctl5_r.inverse && s6[DW];
      assign oneg  = o5_r[k][DW-1];

      always_ff @(posedge clk) begin
        if (en1) pre1_r[k] <= pre_nxt;
        if (en2) v2_r[k] <= s2[DW-1:0];
        if (en3) begin
          v3_r[k] <= v2_r[k];
          t3_r[k] <= TW'(tsum >>> (QUAT_FRAC - 1));
        end
        if (en4) begin
          v4_r[k] <= v3_r[k];
          u4_r[k] <= UW'(usum >>> QUAT_FRAC);
        end
        if (en5) o5_r[k] <= s5[DW-1:0];
        if (en6) begin
          fwd6_r[k] <= (ctl5_r.pos && !ctl5_r.inverse) ? s6[DW-1:0] : o5_r[k];
          ub6_r[k]  <= sc_r[k][DW-1] ? DW'(-sc_r[k]) : sc_r[k];
          dq6_r[k]  <= {(oneg ? DW'(-o5_r[k]) : o5_r[k]), {FRAC_BITS{1'b0}}};
          axis6_r[k].neg   <= oneg ^ sc_r[k][DW-1];
          axis6_r[k].aneg  <= oneg;
          axis6_r[k].bzero <= (sc_r[k] == '0);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
      if (en5) vld5_r <= vld4_r;
      if (en6) vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) ctl1_r <= in_ctl;
    if (en2) ctl2_r <= {ctl1_r.pos, ctl1_r.inverse, ctl1_r.scaled, ctl1_r.err || (|e2)};
    if (en3) ctl3_r <= ctl2_r;
    if (en4) ctl4_r <= ctl3_r;
    if (en5) ctl5_r <= {ctl4_r.pos, ctl4_r.inverse, ctl4_r.scaled, ctl4_r.err || (|e5)};
    if (en6) ctl6_r <= {ctl5_r.pos, ctl5_r.inverse, ctl5_r.scaled, ctl5_r.err || (|e6)};
  end

  // Divider pipeline
  logic                dv_valid [NSTG+1];
  logic                dv_ready [NSTG+1];
  ctl_t                dv_ctl   [NSTG+1];
  axis_t [2:0]         dv_axis  [NSTG+1];
  logic [2:0][DW-1:0]  dv_fwd   [NSTG+1];
  logic [2:0][DW-1:0]  dv_ub    [NSTG+1];
  logic [2:0][DW:0]    dv_rem   [NSTG+1];
  logic [2:0][TOT-1:0] dv_dq    [NSTG+1];

  assign dv_valid[0] = vld6_r;
  assign div_in_ready = dv_ready[0];
  assign dv_ctl[0]   = ctl6_r;
  assign dv_axis[0]  = axis6_r;
  assign dv_fwd[0]   = fwd6_r;
  assign dv_ub[0]    = ub6_r;
  assign dv_rem[0]   = '0;
  assign dv_dq[0]    = dq6_r;
  assign dv_ready[NSTG] = en_out;

  genvar s;
  generate
    for (s = 0; s < NSTG; s++) begin : g_div
      srtv_div_stage #(
        .DW    (DW),
        .FRAC  (FRAC_BITS),
        .STAGE (s),
        .STEPS (STEPS)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[s]),
        .in_ready  (dv_ready[s]),
        .in_ctl    (dv_ctl[s]),
        .in_axis   (dv_axis[s]),
        .in_fwd    (dv_fwd[s]),
        .in_ub     (dv_ub[s]),
        .in_rem    (dv_rem[s]),
        .in_dq     (dv_dq[s]),
        .out_valid (dv_valid[s+1]),
        .out_ready (dv_ready[s+1]),
        .out_ctl   (dv_ctl[s+1]),
        .out_axis  (dv_axis[s+1]),
        .out_fwd   (dv_fwd[s+1]),
        .out_ub    (dv_ub[s+1]),
        .out_rem   (dv_rem[s+1]),
        .out_dq    (dv_dq[s+1])
      );
    end
  endgenerate

  // Output stage: pick the quotient or the forward value and clamp.
  logic                 out_valid_r;
  logic signed [DW-1:0] res_r [3];
  logic signed [DW-1:0] res_nxt [3];
  logic [2:0]           rerr;
  logic                 pos_r, err_r;
  logic                 use_div;

  assign en_out  = !out_valid_r || out_ready;
  assign use_div = dv_ctl[NSTG].inverse && dv_ctl[NSTG].scaled;

  always_comb begin
    logic [TOT-1:0] q;
    logic [TOT-1:0] lim;
    axis_t          ax;
    for (int a = 0; a < 3; a++) begin
      q   = dv_dq[NSTG][a];
      ax  = dv_axis[NSTG][a];
      lim = (TOT'(1) << (DW - 1)) - (ax.neg ? TOT'(0) : TOT'(1));
      rerr[a] = 1'b0;
      if (!use_div) begin
        res_nxt[a] = dv_fwd[NSTG][a];
      end else if (ax.bzero) begin
        rerr[a]    = 1'b1;
        res_nxt[a] = ax.aneg ? MIN_W[DW-1:0] : MAX_W[DW-1:0];
      end else if (q > lim) begin
        rerr[a]    = 1'b1;
        res_nxt[a] = ax.neg ? MIN_W[DW-1:0] : MAX_W[DW-1:0];
      end else begin
        res_nxt[a] = ax.neg ? -q[DW-1:0] : q[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= dv_valid[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      for (int a = 0; a < 3; a++) res_r[a] <= res_nxt[a];
      pos_r <= dv_ctl[NSTG].pos;
      err_r <= dv_ctl[NSTG].err || (|rerr);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = res_r[0];
  assign out_y           = res_r[1];
  assign out_z           = res_r[2];
  assign out_is_position = pos_r;
  assign out_range_error = err_r;

endmodule

// ===== hw/rtl/srtv_checker.sv =====
// Port-level checker for the scale/rotate/translate vector block, with the
// bind that attaches it to the top level. Uses no package; the bind needs the top level.
module srtv_port_props #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_x
);

  // A held result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x))
    else $error("result changed while stalled");

  // With the output register free, the whole pipeline can advance.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled although the output side is free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind scale_rotate_translate_vector srtv_port_props #(
  .DATA_WIDTH (DATA_WIDTH)
) u_srtv_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x)
);

// ===== bench/srtv_checker.sv =====
// Checker for the scale/rotate/translate vector block: it follows register writes,
// predicts every accepted item and compares the results in order.
// Depends on srtv_pkg for op codes, register indexes and the quaternion fraction width.
module srtv_checker
  import srtv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [5:0]  paddr,
  input  logic        [63:0] pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [1:0]  in_op,
  input  logic               in_is_position,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               out_is_position,
  input  logic               out_range_error,
  output int                 fail_count,
  output int                 pending
);

  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               pos;
    logic               err;
  } vec_result_t;

  vec_result_t expected_vectors[$];

  logic [63:0] rot_q;
  longint      trans[3];
  longint      scl[3];

  function automatic longint clamp(longint v, inout bit err);
    if (v > MAXV) begin
      err = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      err = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  function automatic vec_result_t transform(logic [1:0] op, logic pos,
                                            longint x, longint y, longint z);
    vec_result_t r;
    longint      v[3];
    longint      qx, qy, qz, qw, tx, ty, tz, ox, oy, oz;
    bit          err;
    bit          scaled, inverse;
    err = 1'b0;
    scaled = (op == OP_FWD) || (op == OP_INV);
    inverse = (op == OP_INV) || (op == OP_INV_NOSCALE);
    v[0] = x;
    v[1] = y;
    v[2] = z;
    qx = longint'($signed(rot_q[15:0]));
    qy = longint'($signed(rot_q[31:16]));
    qz = longint'($signed(rot_q[47:32]));
    qw = longint'($signed(rot_q[63:48]));
    if (inverse) begin
      qx = -qx;
      qy = -qy;
      qz = -qz;
      if (pos) for (int k = 0; k < 3; k++) v[k] = clamp(v[k] - trans[k], err);
    end else if (scaled) begin
      for (int k = 0; k < 3; k++) v[k] = clamp((v[k] * scl[k]) >>> 16, err);
    end
    // t = 2*cross(q,v) and v' = v + w*t + cross(q,t), each floored exactly.
    tx = (qy * v[2] - qz * v[1]) >>> (QUAT_FRAC - 1);
    ty = (qz * v[0] - qx * v[2]) >>> (QUAT_FRAC - 1);
    tz = (qx * v[1] - qy * v[0]) >>> (QUAT_FRAC - 1);
    ox = v[0] + ((qw * tx + qy * tz - qz * ty) >>> QUAT_FRAC);
    oy = v[1] + ((qw * ty + qz * tx - qx * tz) >>> QUAT_FRAC);
    oz = v[2] + ((qw * tz + qx * ty - qy * tx) >>> QUAT_FRAC);
    v[0] = clamp(ox, err);
    v[1] = clamp(oy, err);
    v[2] = clamp(oz, err);
    if (inverse) begin
      if (scaled) begin
        for (int k = 0; k < 3; k++) begin
          if (scl[k] == 0) begin
            err = 1'b1;
            v[k] = (v[k] < 0) ? MINV : MAXV;
          end else begin
            v[k] = clamp((v[k] * 64'sd65536) / scl[k], err);
          end
        end
      end
    end else if (pos) begin
      for (int k = 0; k < 3; k++) v[k] = clamp(v[k] + trans[k], err);
    end
    r.x = v[0][31:0];
    r.y = v[1][31:0];
    r.z = v[2][31:0];
    r.pos = pos;
    r.err = err;
    return r;
  endfunction

  assign pending = expected_vectors.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    vec_result_t want;
    if (!rst_n) begin
      rot_q <= 64'h4000_0000_0000_0000;
      for (int k = 0; k < 3; k++) begin
        trans[k] <= 0;
        scl[k] <= 64'sd65536;
      end
      expected_vectors.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_ROTATION: rot_q <= pwdata;
          REG_TRANS_X:  trans[0] <= longint'($signed(pwdata[31:0]));
          REG_TRANS_Y:  trans[1] <= longint'($signed(pwdata[31:0]));
          REG_TRANS_Z:  trans[2] <= longint'($signed(pwdata[31:0]));
          REG_SCALE_X:  scl[0] <= longint'($signed(pwdata[31:0]));
          REG_SCALE_Y:  scl[1] <= longint'($signed(pwdata[31:0]));
          REG_SCALE_Z:  scl[2] <= longint'($signed(pwdata[31:0]));
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_vectors.push_back(transform(in_op, in_is_position, in_x, in_y, in_z));
      if (out_valid && out_ready) begin
        if (expected_vectors.size() == 0) begin
          $error("result item with no expected item waiting");
          fail_count++;
        end else begin
          want = expected_vectors.pop_front();
          if (out_x !== want.x) begin
            $error("out_x expected %0d actual %0d", want.x, out_x);
            fail_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y expected %0d actual %0d", want.y, out_y);
            fail_count++;
          end
          if (out_z !== want.z) begin
            $error("out_z expected %0d actual %0d", want.z, out_z);
            fail_count++;
          end
          if (out_is_position !== want.pos) begin
            $error("out_is_position expected %0d actual %0d", want.pos, out_is_position);
            fail_count++;
          end
          if (out_range_error !== want.err) begin
            $error("out_range_error expected %0d actual %0d", want.err, out_range_error);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/scale_rotate_translate_vector_test.sv =====
// Top of the scale/rotate/translate vector bench: clock, reset, register
// phases, bursty item stimulus and a stalling receiver. Depends on srtv_pkg,
// srtv_checker and the block itself.
module scale_rotate_translate_vector_test;
  import srtv_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic        [5:0]  paddr = '0;
  logic        [63:0] pwdata = '0;
  logic        [63:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [1:0]  in_op = OP_FWD;
  logic               in_is_position = 1'b0;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic signed [31:0] in_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_is_position;
  logic               out_range_error;
  int                 fail_count;
  int                 pending;
  int                 burst_left = 0;
  int                 cycle_count = 0;

  scale_rotate_translate_vector DUT (.*);

  srtv_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver switches between random stall patterns and twice holds off
  // for a long stretch so that the pipeline fills and stalls its input.
  initial begin
    int hold;
    int mode;
    hold = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count % 250 == 0) mode = $urandom_range(0, 3);
      if (cycle_count == 500 || cycle_count == 1500) hold = 400;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 2) == 0);
          default: out_ready <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [2:0] index, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(logic [1:0] op, logic pos, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_is_position <= pos;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for a clock edge first so that the last accepted item is already counted.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 6))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      3: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_rotation();
    case ($urandom_range(0, 5))
      0: return 64'h4000_0000_0000_0000;
      1: return 64'h0000_0000_0000_4000;
      2: return 64'h2d41_2d41_0000_0000;
      3: return {16'h376d, 16'h0000, 16'h1000, 16'h1000};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0001_0000;
      2: return 32'hffff_0000;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[4];
    edge_vals = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: every op on both item kinds, the range ends, and a zero vector.
    for (int op = 0; op < 4; op++) begin
      send_item(op[1:0], 1'b0, edge_vals[op], 32'h7fff_ffff, 32'h8000_0000);
      send_item(op[1:0], 1'b1, 32'h8000_0000, edge_vals[op], 32'h7fff_ffff);
    end
    send_item(OP_FWD, 1'b1, 32'h0, 32'h0, 32'h0);
    send_item(OP_INV, 1'b0, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
    drain();

    // Extreme settings: zero and range-end scales, range-end translations on two axes and
    // a quaternion with every field at its most negative value.
    write_reg(REG_ROTATION, 64'h8000_8000_8000_8000);
    write_reg(REG_TRANS_X, 64'h7fff_ffff);
    write_reg(REG_TRANS_Y, 64'h8000_0000);
    write_reg(REG_TRANS_Z, 64'h0001_0000);
    write_reg(REG_SCALE_X, 64'h0);
    write_reg(REG_SCALE_Y, 64'h8000_0000);
    write_reg(REG_SCALE_Z, 64'h7fff_ffff);
    write_reg(3'd7, 64'hdead_beef);
    for (int op = 0; op < 4; op++) begin
      send_item(op[1:0], 1'b1, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
      send_item(op[1:0], 1'b0, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    end
    send_item(OP_INV, 1'b0, 32'hffff_0000, 32'h1, 32'h0);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      write_reg(REG_ROTATION, rand_rotation());
      write_reg(REG_TRANS_X, {32'h0, rand_comp()});
      write_reg(REG_TRANS_Y, {32'h0, rand_comp()});
      write_reg(REG_TRANS_Z, {32'h0, rand_comp()});
      write_reg(REG_SCALE_X, {32'h0, rand_scale()});
      write_reg(REG_SCALE_Y, {32'h0, rand_scale()});
      write_reg(REG_SCALE_Z, {32'h0, rand_scale()});
      repeat (118)
        send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_comp(),
                  rand_comp(), rand_comp());
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
